// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the execute unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/amx_pkg.sv =====
package amx_pkg;

	localparam int REQ_W = 4;
	localparam int ADDR_W = 8;
	localparam int ADDR_SPAN = 256;
	localparam int FIELD_W = 32;
	localparam int PC_W = 8;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 48;

	localparam int S_REQ_LSB = 0;
	localparam int S_ADDR_LSB = S_REQ_LSB + REQ_W;
	localparam int S_IMM_LSB = S_ADDR_LSB + ADDR_W;
	localparam int S_IN_LSB = S_IMM_LSB + FIELD_W;
	localparam int S_USED_W = S_IN_LSB + FIELD_W;

	localparam int M_ACC_LSB = 0;
	localparam int M_PC_LSB = M_ACC_LSB + FIELD_W;
	localparam int M_HALT_LSB = M_PC_LSB + PC_W;
	localparam int M_USED_W = M_HALT_LSB + 1;

	typedef enum logic [REQ_W-1:0] {
		OP_IN  = 4'd0,
		OP_OUT = 4'd1,
		OP_LDA = 4'd2,
		OP_LDI = 4'd3,
		OP_STA = 4'd4,
		OP_ADD = 4'd5,
		OP_SUB = 4'd6,
		OP_JMP = 4'd7,
		OP_JEZ = 4'd8,
		OP_JGZ = 4'd9,
		OP_HLT = 4'd10
	} op_t;

endpackage

// ===== hdl/amx_ram.sv =====
module amx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/accumulator_machine_execute.sv =====
// Execute unit of a small accumulator machine.
// The slave channel carries one fetched instruction per transaction. The
// master channel returns one transaction per instruction with the
// accumulator, the next program counter and the halt flag; tuser marks an
// OUT instruction executed while not halted, whose accumulator value is the machine's output.
// An instruction is registered on acceptance while its data memory word is
// read from the RAM; it executes once the result register is empty or being
// taken, and its result is then registered on the master side.
// One instruction is taken every cycle while the receiver keeps up; a store
// in one cycle is forwarded to a load that is accepted in the same cycle.
// When the receiver stalls, the result register holds, the executing
// instruction waits, and tready drops once both are occupied.
// Reset clears the accumulator, program counter, halt flag and the per-word
// valid bits of the data memory, so every word reads as zero until it is
// stored. There is no clearing pass. After HLT every instruction returns
// the unchanged state with the halt flag set.
`include "assert_macros.svh"

module accumulator_machine_execute #(
	parameter int MEM_WORDS = 256,
	parameter int ACC_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: req_type, operand_addr, immediate, in_value.
	input  logic [amx_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0: acc_value, next_pc, halted.
	output logic [amx_pkg::M_TDATA_W-1:0]  m_tdata,
	// Fields from bit 0: out_strobe.
	output logic [0:0]                     m_tuser
);

	localparam int IDX_W = $clog2(MEM_WORDS);

	logic [IDX_W-1:0] addr_map [amx_pkg::ADDR_SPAN];

	for (genvar g = 0; g < amx_pkg::ADDR_SPAN; g++) begin : g_addr_map
		localparam int Wrap = g % MEM_WORDS;
		assign addr_map[g] = IDX_W'(Wrap);
	end

	logic                             accept;
	logic                             adv;
	logic                             valid_s1;
	logic [amx_pkg::REQ_W-1:0]        req_s1;
	logic [amx_pkg::ADDR_W-1:0]       addr_s1;
	logic [IDX_W-1:0]                 idx_s1;
	logic signed [amx_pkg::FIELD_W-1:0] imm_s1;
	logic signed [amx_pkg::FIELD_W-1:0] in_s1;
	logic                             fwd_s1;
	logic [ACC_BITS-1:0]              fwd_data_s1;
	logic                             wvld_s1;

	logic [amx_pkg::ADDR_W-1:0]       s_addr;
	logic [IDX_W-1:0]                 rd_idx;
	logic [ACC_BITS-1:0]              ram_rdata;
	logic [MEM_WORDS-1:0]             mem_vld_q;
	logic [ACC_BITS-1:0]              mem_word;

	logic [ACC_BITS-1:0]              acc_q;
	logic [amx_pkg::PC_W-1:0]         pc_q;
	logic                             halt_q;

	logic [ACC_BITS-1:0]              acc_nxt;
	logic [amx_pkg::PC_W-1:0]         pc_nxt;
	logic                             halt_nxt;
	logic                             strobe_nxt;
	logic                             sta_c;
	logic                             mem_we;

	logic                             m_valid_q;
	logic [amx_pkg::M_TDATA_W-1:0]    m_data_q;
	logic                             m_user_q;

	assign adv = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept = s_tvalid && s_tready;

	assign s_addr = s_tdata[amx_pkg::S_ADDR_LSB +: amx_pkg::ADDR_W];
	assign rd_idx = addr_map[s_addr];

	amx_ram #(
		.WIDTH(ACC_BITS),
		.DEPTH(MEM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(idx_s1),
		.wdata(acc_q),
		.re   (accept),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= s_tdata[amx_pkg::S_REQ_LSB +: amx_pkg::REQ_W];
			addr_s1     <= s_addr;
			idx_s1      <= rd_idx;
			imm_s1      <= s_tdata[amx_pkg::S_IMM_LSB +: amx_pkg::FIELD_W];
			in_s1       <= s_tdata[amx_pkg::S_IN_LSB +: amx_pkg::FIELD_W];
			fwd_s1      <= mem_we && (idx_s1 == rd_idx);
			fwd_data_s1 <= acc_q;
			wvld_s1     <= mem_vld_q[rd_idx];
		end
	end

	assign mem_word = fwd_s1 ? fwd_data_s1 : (wvld_s1 ? ram_rdata : '0);

	always_comb begin
		acc_nxt    = acc_q;
		pc_nxt     = pc_q;
		halt_nxt   = halt_q;
		strobe_nxt = 1'b0;
		sta_c      = 1'b0;
		if (!halt_q) begin
			pc_nxt = pc_q + amx_pkg::PC_W'(1);
			case (amx_pkg::op_t'(req_s1))
				amx_pkg::OP_IN: begin
					acc_nxt = ACC_BITS'(in_s1);
				end
				amx_pkg::OP_OUT: begin
					strobe_nxt = 1'b1;
				end
				amx_pkg::OP_LDA: begin
					acc_nxt = mem_word;
				end
				amx_pkg::OP_LDI: begin
					acc_nxt = ACC_BITS'(imm_s1);
				end
				amx_pkg::OP_STA: begin
					sta_c = 1'b1;
				end
				amx_pkg::OP_ADD: begin
					acc_nxt = acc_q + mem_word;
				end
				amx_pkg::OP_SUB: begin
					acc_nxt = acc_q - mem_word;
				end
				amx_pkg::OP_JMP: begin
					pc_nxt = addr_s1;
				end
				amx_pkg::OP_JEZ: begin
					if (acc_q == '0) begin
						pc_nxt = addr_s1;
					end
				end
				amx_pkg::OP_JGZ: begin
					if ((acc_q != '0) && !acc_q[ACC_BITS-1]) begin
						pc_nxt = addr_s1;
					end
				end
				amx_pkg::OP_HLT: begin
					halt_nxt = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign mem_we = adv && sta_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pc_q      <= '0;
			halt_q    <= 1'b0;
			mem_vld_q <= '0;
		end else if (adv) begin
			acc_q  <= acc_nxt;
			pc_q   <= pc_nxt;
			halt_q <= halt_nxt;
			if (sta_c) begin
				mem_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {
				(amx_pkg::M_TDATA_W - amx_pkg::M_USED_W)'(0),
				halt_nxt,
				pc_nxt,
				amx_pkg::FIELD_W'($signed(acc_nxt))
			};
			m_user_q <= strobe_nxt;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

	`AMX_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halt_q, halt_q, "halt flag cleared without reset")
	`AMX_ASSERT_NEXT(a_halt_frozen, clk, arst_n, adv && halt_q, $stable(pc_q) && $stable(acc_q), "state changed after halt")
	`AMX_ASSERT_NOW(a_no_store_halted, clk, arst_n, mem_we, !halt_q, "memory written while halted")
	`AMX_ASSERT_NEXT(a_result_follows, clk, arst_n, adv, m_tvalid, "executed instruction produced no result")

endmodule

// ===== dv/accumulator_machine_execute_test.sv =====
`timescale 1ns / 1ps

module accumulator_machine_execute_test;

	localparam logic [3:0] OP_RSVD_LO = 4'd11;
	localparam logic [3:0] OP_RSVD_HI = 4'd15;
	localparam int RANDOM_ITEMS = 1520;
	localparam int CALM_TAIL = 150;

	typedef struct packed {
		logic [3:0]  op;
		logic [7:0]  addr;
		logic [31:0] imm;
		logic [31:0] inv;
	} instr_t;

	typedef struct packed {
		logic [31:0] acc;
		logic [7:0]  pc;
		logic        strobe;
		logic        halted;
	} exec_state_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [amx_pkg::S_TDATA_W-1:0]  s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [amx_pkg::M_TDATA_W-1:0]  m_tdata;
	logic [0:0]                     m_tuser;

	logic [31:0] accum = '0;
	logic [7:0]  prog_ctr = '0;
	logic [31:0] data_mem [0:255];
	logic        halt_flag = 1'b0;

	instr_t      program_q[$];
	exec_state_t pending_states[$];
	instr_t      cur_instr;
	int          item_total = 0;
	int          instr_accepted = 0;
	int          states_checked = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          error_count = 0;

	accumulator_machine_execute uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic exec_state_t execute_instr(instr_t ins);
		exec_state_t r;
		logic [7:0] pc_next;
		r.strobe = 1'b0;
		if (!halt_flag) begin
			pc_next = prog_ctr + 8'd1;
			case (ins.op)
				amx_pkg::OP_IN: accum = ins.inv;
				amx_pkg::OP_OUT: r.strobe = 1'b1;
				amx_pkg::OP_LDA: accum = data_mem[ins.addr];
				amx_pkg::OP_LDI: accum = ins.imm;
				amx_pkg::OP_STA: data_mem[ins.addr] = accum;
				amx_pkg::OP_ADD: accum = accum + data_mem[ins.addr];
				amx_pkg::OP_SUB: accum = accum - data_mem[ins.addr];
				amx_pkg::OP_JMP: pc_next = ins.addr;
				amx_pkg::OP_JEZ: if (accum == '0) pc_next = ins.addr;
				amx_pkg::OP_JGZ: if (accum != '0 && !accum[31]) pc_next = ins.addr;
				amx_pkg::OP_HLT: halt_flag = 1'b1;
				default: ;
			endcase
			prog_ctr = pc_next;
		end
		r.acc = accum;
		r.pc = prog_ctr;
		r.halted = halt_flag;
		return r;
	endfunction

	function automatic instr_t make_instr(logic [3:0] op, logic [7:0] addr, logic [31:0] imm,
			logic [31:0] inv);
		instr_t i;
		i.op = op;
		i.addr = addr;
		i.imm = imm;
		i.inv = inv;
		return i;
	endfunction

	function automatic void queue_instr(instr_t i);
		program_q.insert(program_q.size(), i);
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: w = 32'h0000_0000;
					1: w = 32'h0000_0001;
					2: w = 32'hFFFF_FFFF;
					3: w = 32'h7FFF_FFFF;
					default: w = 32'h8000_0000;
				endcase
			end
			1, 2: w = $urandom_range(0, 6) - 3;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] pick_addr();
		logic [7:0] a;
		case ($urandom_range(0, 5))
			0, 1, 2: a = 8'($urandom_range(0, 7));
			3: a = 8'($urandom_range(248, 255));
			default: a = 8'($urandom_range(0, 255));
		endcase
		return a;
	endfunction

	function automatic instr_t random_instr();
		logic [3:0] op;
		if ($urandom_range(0, 99) < 2)
			op = 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
		else
			op = 4'($urandom_range(amx_pkg::OP_IN, amx_pkg::OP_JGZ));
		return make_instr(op, pick_addr(), pick_word(), pick_word());
	endfunction

	task automatic add_directed();
		queue_instr(make_instr(amx_pkg::OP_IN, 8'($urandom), $urandom, 32'h7FFF_FFFF));
		queue_instr(make_instr(amx_pkg::OP_OUT, 8'($urandom), $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_STA, 8'd255, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_IN, 8'($urandom), $urandom, 32'h8000_0000));
		queue_instr(make_instr(amx_pkg::OP_STA, 8'd0, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_ADD, 8'd255, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_OUT, 8'($urandom), $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_LDI, 8'($urandom), 32'h7FFF_FFFF, $urandom));
		queue_instr(make_instr(amx_pkg::OP_ADD, 8'd255, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_SUB, 8'd0, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_LDI, 8'($urandom), 32'h8000_0000, $urandom));
		queue_instr(make_instr(amx_pkg::OP_SUB, 8'd255, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_JGZ, 8'd200, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_LDA, 8'd17, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_JEZ, 8'd255, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_JGZ, 8'd3, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_LDI, 8'($urandom), 32'hFFFF_FFFF, $urandom));
		queue_instr(make_instr(amx_pkg::OP_JGZ, 8'd10, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_JEZ, 8'd0, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_JMP, 8'd0, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_JMP, 8'd255, $urandom, $urandom));
		queue_instr(make_instr(amx_pkg::OP_OUT, 8'($urandom), $urandom, $urandom));
		queue_instr(make_instr(OP_RSVD_LO, 8'($urandom), $urandom, $urandom));
		queue_instr(make_instr(OP_RSVD_HI, 8'($urandom), $urandom, $urandom));
	endtask

	task automatic add_random();
		logic [7:0] a;
		while (program_q.size() < RANDOM_ITEMS + 24) begin
			a = pick_addr();
			case ($urandom_range(0, 11))
				0: begin
					queue_instr(make_instr(amx_pkg::OP_LDA, a, $urandom, $urandom));
					queue_instr(make_instr(amx_pkg::OP_SUB, a, $urandom, $urandom));
					queue_instr(make_instr(amx_pkg::OP_JEZ, 8'($urandom), $urandom,
						$urandom));
				end
				1: begin
					queue_instr(make_instr(amx_pkg::OP_LDI, 8'($urandom),
						$urandom_range(1, 9), $urandom));
					queue_instr(make_instr(amx_pkg::OP_STA, a, $urandom, $urandom));
					queue_instr(make_instr(amx_pkg::OP_ADD, a, $urandom, $urandom));
					queue_instr(make_instr(amx_pkg::OP_JGZ, 8'($urandom), $urandom,
						$urandom));
				end
				default: queue_instr(random_instr());
			endcase
		end
		// Halting ends all useful work, so it comes last, followed by ignored items.
		queue_instr(make_instr(amx_pkg::OP_HLT, 8'($urandom), $urandom, $urandom));
		repeat (6) queue_instr(random_instr());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid && s_tready) begin
				pending_states.insert(pending_states.size(), execute_instr(cur_instr));
				instr_accepted++;
			end
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (program_q.size() > 0 && instr_accepted < item_total - CALM_TAIL
					&& (instr_accepted / 128) % 4 != 3 && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(1, 17) - 1;
				s_tvalid <= 1'b0;
			end else if (program_q.size() > 0) begin
				cur_instr = program_q.pop_front();
				s_tdata <= {4'b0, cur_instr.inv, cur_instr.imm, cur_instr.addr, cur_instr.op};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		exec_state_t exp_st;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_states.size() == 0) begin
					$display("%0t: unexpected result, actual tdata %h tuser %b",
						$time, m_tdata, m_tuser);
					error_count++;
				end else begin
					exp_st = pending_states.pop_front();
					states_checked++;
					if (m_tdata[amx_pkg::M_ACC_LSB +: amx_pkg::FIELD_W] !== exp_st.acc) begin
						$display("%0t: acc_value expected %h actual %h", $time, exp_st.acc,
							m_tdata[amx_pkg::M_ACC_LSB +: amx_pkg::FIELD_W]);
						error_count++;
					end
					if (m_tdata[amx_pkg::M_PC_LSB +: amx_pkg::PC_W] !== exp_st.pc) begin
						$display("%0t: next_pc expected %h actual %h", $time, exp_st.pc,
							m_tdata[amx_pkg::M_PC_LSB +: amx_pkg::PC_W]);
						error_count++;
					end
					if (m_tdata[amx_pkg::M_HALT_LSB] !== exp_st.halted) begin
						$display("%0t: halted expected %b actual %b", $time, exp_st.halted,
							m_tdata[amx_pkg::M_HALT_LSB]);
						error_count++;
					end
					if (m_tuser[0] !== exp_st.strobe) begin
						$display("%0t: out_strobe expected %b actual %b", $time, exp_st.strobe,
							m_tuser[0]);
						error_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else if (states_checked < item_total - CALM_TAIL
					&& (states_checked / 128) % 4 != 1 && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(1, 17) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		for (int i = 0; i < 256; i++) data_mem[i] = '0;
		add_directed();
		add_random();
		item_total = program_q.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (program_q.size() != 0 || s_tvalid || pending_states.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0 && pending_states.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== accumulator_machine_execute.f =====
+incdir+hdl
hdl/amx_pkg.sv
hdl/amx_ram.sv
hdl/accumulator_machine_execute.sv
dv/accumulator_machine_execute_test.sv
